/* hdl/sliding_window_moving_average_core_defines.svh */
// ----------------------------------------------------------------------------
// Moving average core assertion macros
// Shared property wrappers for the moving average core assertions.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MOVING_AVERAGE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MOVING_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWMA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/swma_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average package
// Item kinds and divider status shared by the core and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swma_pkg;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

/* hdl/swma_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/swma_div.sv */
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swma_div
    import swma_pkg::*;
#(
    parameter int SUM_W = 22,
    parameter int CNT_W = 7,
    parameter int SMP_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output t_div_status             o_status,
    output logic signed [SMP_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic [SMP_W-1:0]  r_q;

    logic [SUM_W-1:0]  w_mag;
    logic [CNT_W:0]    w_trial;
    logic              w_bit;
    logic [SUM_W-1:0]  w_qfin;

    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_bit   = (w_trial >= {1'b0, r_div});
    assign w_qfin  = {r_quo[SUM_W-2:0], w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
                r_rem  <= '0;
                r_quo  <= w_mag;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
            end else if (r_busy) begin
                // shift the next dividend bit in, keep the remainder if it fits
                r_rem <= w_bit ? CNT_W'(w_trial - {1'b0, r_div}) : CNT_W'(w_trial);
                r_quo <= w_qfin;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? SMP_W'(-w_qfin) : SMP_W'(w_qfin);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = signed'(r_q);

endmodule

/* hdl/sliding_window_moving_average_core.sv */
// ----------------------------------------------------------------------------
// Sliding window moving average core
// A push stores a sample in a circular window and returns the new average,
// sum over fill count truncated toward zero; the running sum is kept exactly.
// A push updates the sum and then waits on the serial divider, which produces
// one quotient bit per cycle. A dump returns the stored samples oldest first,
// one entry at a time through the window RAM read port; an empty window gives
// a single result with the empty flag in tuser.
// Writing the window size clears the window; 0 acts as 1 and values above
// WINDOW_MAX act as WINDOW_MAX. Input is taken only while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_moving_average_core_defines.svh"

module sliding_window_moving_average_core
    import swma_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration: window size
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_cfg_data,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,   // sample
    input  logic                    i_s_axis_tuser,             // kind
    // result stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // average, count, entry_value
    output logic [((2*SAMPLE_WIDTH+$clog2(WINDOW_MAX+1)+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                    o_m_axis_tuser,             // empty_dump
    output logic                    o_m_axis_tlast              // last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
    localparam int OUT_W = ((2 * SAMPLE_WIDTH + CW + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_DIV,
        S_DUMP_RD,
        S_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_size, n_size;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [SW-1:0]    r_avg, n_avg;
    logic signed [SW-1:0]    r_sample, n_sample;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_i, n_i;
    logic                    r_mvalid, n_mvalid;
    logic signed [SW-1:0]    r_entry, n_entry;
    logic                    r_last, n_last;
    logic                    r_empty, n_empty;

    logic                    w_full;
    logic [CW-1:0]           w_pos_inc;
    logic [AW-1:0]           w_pos_next;
    logic [CW-1:0]           w_idx_inc;
    logic [AW-1:0]           w_idx_next;
    logic [CW-1:0]           w_cfg_size;
    logic                    w_in_xfer;
    logic                    w_out_xfer;
    logic                    w_cfg_xfer;
    logic signed [SUM_W-1:0] w_new_ext;
    logic signed [SUM_W-1:0] w_old_ext;

    logic                    w_ram_we;
    logic [AW-1:0]           w_rd_addr;
    logic [SW-1:0]           w_rd_data;

    t_div_status             w_div_st;
    logic                    w_div_start;
    logic signed [SW-1:0]    w_div_q;

    assign w_full     = (r_count == r_size);
    assign w_pos_inc  = CW'(r_pos) + CW'(1);
    assign w_pos_next = (w_pos_inc == r_size) ? '0 : w_pos_inc[AW-1:0];
    assign w_idx_inc  = CW'(r_idx) + CW'(1);
    assign w_idx_next = (w_idx_inc == r_size) ? '0 : w_idx_inc[AW-1:0];
    assign w_cfg_size = (i_cfg_data == '0)            ? CW'(1) :
                        (i_cfg_data > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : i_cfg_data;

    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_cfg_xfer      = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer      = r_mvalid && i_m_axis_tready;

    assign w_new_ext = SUM_W'(r_sample);
    assign w_old_ext = SUM_W'(signed'(w_rd_data));

    // the RAM registers its read data, so the read address is set up ahead of use
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = (i_s_axis_tuser == KIND_DUMP && !w_full) ? '0 : r_pos;
            S_OUT:   w_rd_addr = w_idx_next;
            default: w_rd_addr = r_idx;
        endcase
    end

    assign w_ram_we    = (r_state == S_PUSH);
    assign w_div_start = (r_state == S_PUSH);

    swma_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    swma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CW),
        .SMP_W (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_status   (w_div_st),
        .o_quotient (w_div_q)
    );

    always_comb begin
        n_state  = r_state;
        n_size   = r_size;
        n_count  = r_count;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_avg    = r_avg;
        n_sample = r_sample;
        n_idx    = r_idx;
        n_i      = r_i;
        n_mvalid = r_mvalid;
        n_entry  = r_entry;
        n_last   = r_last;
        n_empty  = r_empty;

        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_xfer) begin
                    // new size: drop the window
                    n_size  = w_cfg_size;
                    n_count = '0;
                    n_pos   = '0;
                    n_sum   = '0;
                    n_avg   = '0;
                end else if (w_in_xfer) begin
                    if (i_s_axis_tuser == KIND_PUSH) begin
                        n_sample = signed'(i_s_axis_tdata[SW-1:0]);
                        n_state  = S_PUSH;
                    end else if (r_count == '0) begin
                        n_entry  = '0;
                        n_last   = 1'b1;
                        n_empty  = 1'b1;
                        n_mvalid = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = w_full ? r_pos : '0;
                        n_i     = '0;
                        n_state = S_DUMP_RD;
                    end
                end
            end
            S_PUSH: begin
                if (w_full) begin
                    n_sum = r_sum - w_old_ext + w_new_ext;
                end else begin
                    n_sum   = r_sum + w_new_ext;
                    n_count = r_count + 1'b1;
                end
                n_pos   = w_pos_next;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_st.done) begin
                    n_avg    = w_div_q;
                    n_entry  = '0;
                    n_last   = 1'b1;
                    n_empty  = 1'b0;
                    n_mvalid = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_DUMP_RD: begin
                n_entry  = signed'(w_rd_data);
                n_last   = ((r_i + 1'b1) == r_count);
                n_empty  = 1'b0;
                n_mvalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_mvalid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance to the next entry, its read is already issued
                        n_idx   = w_idx_next;
                        n_i     = r_i + 1'b1;
                        n_state = S_DUMP_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= CW'(WINDOW_MAX);
            r_count  <= '0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_avg    <= '0;
            r_idx    <= '0;
            r_i      <= '0;
            r_mvalid <= 1'b0;
            r_last   <= 1'b0;
            r_empty  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_avg    <= n_avg;
            r_idx    <= n_idx;
            r_i      <= n_i;
            r_mvalid <= n_mvalid;
            r_last   <= n_last;
            r_empty  <= n_empty;
        end
        r_sample <= n_sample;
        r_entry  <= n_entry;
    end

    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = OUT_W'({r_entry, r_count, r_avg});
    assign o_m_axis_tuser  = r_empty;
    assign o_m_axis_tlast  = r_last;

    `SWMA_ASSERT_IMPLY(a_count_in_window, i_clk, i_rst_n, 1'b1, r_count <= r_size, "fill count beyond window size")
    `SWMA_ASSERT_IMPLY(a_pos_in_window, i_clk, i_rst_n, 1'b1, CW'(r_pos) < r_size, "write position beyond window size")
    `SWMA_ASSERT_IMPLY(a_div_in_div_state, i_clk, i_rst_n, w_div_st.busy, r_state == S_DIV, "divider busy outside divide state")
    `SWMA_ASSERT_IMPLY(a_no_result_when_ready, i_clk, i_rst_n, o_s_axis_tready, !o_m_axis_tvalid, "result pending while taking input")
    `SWMA_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, w_cfg_xfer, r_count == '0 && r_sum == '0 && r_state == S_IDLE, "window not cleared after size write")

endmodule
